// ----- sv/fcf_pkg.sv -----
package fcf_pkg;

  localparam int DATA_W   = 16;
  localparam int IDX_W    = 8;
  localparam int CMD_W    = 2;
  localparam int TAPS_DEF = 256;

  // Command codes carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TAP    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic adv;       // take the new sample into the partial sums
    logic clr_hist;  // zero the partial sums (history cleared)
    logic clr_taps;  // zero the coefficients and the partial sums
  } cell_ctl_t;

endpackage

// ----- sv/fcf_cell.sv -----
module fcf_cell #(
  parameter int ACC_W = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fcf_pkg::cell_ctl_t              ctl,
  input  logic                            tap_we,
  input  logic signed [fcf_pkg::DATA_W-1:0] coef,
  input  logic signed [fcf_pkg::DATA_W-1:0] x,
  input  logic signed [ACC_W-1:0]         s_in,
  output logic signed [ACC_W-1:0]         s_out
);

  logic signed [fcf_pkg::DATA_W-1:0]   h_r, h_nxt;
  logic signed [ACC_W-1:0]             s_r, s_nxt;
  logic signed [2*fcf_pkg::DATA_W-1:0] prod;

  assign prod = h_r * x;

  always_comb begin
    h_nxt = h_r;
    if (ctl.clr_taps) begin
      h_nxt = '0;
    end else if (tap_we) begin
      h_nxt = coef;
    end
  end

  // Transposed form: this cell's product plus the neighbor's sum, passed one step down
  always_comb begin
    s_nxt = s_r;
    if (ctl.clr_taps || ctl.clr_hist) begin
      s_nxt = '0;
    end else if (ctl.adv) begin
      s_nxt = ACC_W'(prod) + s_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
      s_r <= '0;
    end else begin
      h_r <= h_nxt;
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

// ----- sv/fcf_outreg.sv -----
module fcf_outreg #(
  parameter int ACC_W = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              zero,
  input  logic signed [ACC_W-1:0]           sum,
  output logic                              can_load,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [fcf_pkg::DATA_W-1:0] out_sample,
  output logic                              out_clip
);

  localparam int QW = ACC_W + 1 - (fcf_pkg::DATA_W - 1);
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);

  logic signed [ACC_W:0]              rnd;
  logic signed [QW-1:0]               q;
  logic signed [fcf_pkg::DATA_W-1:0]  sat;
  logic                               clip;
  logic                               valid_r, valid_nxt;
  logic signed [fcf_pkg::DATA_W-1:0]  data_r, data_nxt;
  logic                               clip_r, clip_nxt;

  // Round half up to Q1.15, then saturate
  assign rnd = {sum[ACC_W-1], sum} + (ACC_W+1)'(16384);
  assign q   = QW'(rnd >>> (fcf_pkg::DATA_W - 1));

  always_comb begin
    sat  = q[fcf_pkg::DATA_W-1:0];
    clip = 1'b0;
    if (q > QMAX) begin
      sat  = QMAX[fcf_pkg::DATA_W-1:0];
      clip = 1'b1;
    end else if (q < QMIN) begin
      sat  = QMIN[fcf_pkg::DATA_W-1:0];
      clip = 1'b1;
    end
  end

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    clip_nxt  = clip_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = zero ? '0 : sat;
      clip_nxt  = zero ? 1'b0 : clip;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    clip_r <= clip_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_sample = data_r;
  assign out_clip   = clip_r;

endmodule

// ----- sv/fir_convolution_filter_core.sv -----
// Channel | Handshake             | tdata (low bit up)                   | tuser
// --------+-----------------------+--------------------------------------+-------------------
// in      | in_tvalid/in_tready   | tap_index, coefficient, sample (40 b) | cmd (0/1/2)
// out     | out_tvalid/out_tready | filtered_sample (16 b)               | clipped
//
// One command transfer per cycle while in_tready is high. A chain of TAPS
// cells in transposed form holds one coefficient and one partial sum each and
// passes the sum to its neighbor on every sample. A result is registered in
// the first cell's sum register, then in the output register on out_tdata.
// rst_n (synchronous) zeroes taps, sums and the ready flag at once.
// A stalled output holds one pending sum; further input stalls behind it.
module fir_convolution_filter_core #(
  parameter int TAPS = fcf_pkg::TAPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] tap_index, [23:8] coefficient, [39:24] sample
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] filtered_sample
  output logic        out_tuser   // [0] clipped
);

  localparam int ACC_W = 2 * fcf_pkg::DATA_W + $clog2(TAPS);

  logic                              xfer;
  logic [fcf_pkg::IDX_W-1:0]         tap_index;
  logic signed [fcf_pkg::DATA_W-1:0] coefficient;
  logic signed [fcf_pkg::DATA_W-1:0] sample;
  logic                              is_sample, is_tap, is_clear;
  fcf_pkg::cell_ctl_t                ctl;

  logic ready_r, ready_nxt;       // a tap has been written
  logic pend_r, pend_nxt;         // result in the first cell awaits the output stage
  logic pzero_r, pzero_nxt;       // that result is the not-ready zero
  logic can_load;

  logic signed [ACC_W-1:0]          s_chain [TAPS+1];
  logic signed [fcf_pkg::DATA_W-1:0] res_sample;

  assign tap_index   = in_tdata[7:0];
  assign coefficient = in_tdata[23:8];
  assign sample      = in_tdata[39:24];

  assign xfer      = in_tvalid && in_tready;
  assign is_sample = (in_tuser == fcf_pkg::CMD_SAMPLE);
  assign is_tap    = (in_tuser == fcf_pkg::CMD_TAP);
  assign is_clear  = (in_tuser == fcf_pkg::CMD_CLEAR);

  // Hold input while a result waits and the output stage cannot take it
  assign in_tready = !pend_r || can_load;

  // Advance the chain only on samples after the first tap write
  assign ctl.adv      = xfer && is_sample && ready_r;
  assign ctl.clr_hist = xfer && is_tap;
  assign ctl.clr_taps = xfer && is_clear;

  always_comb begin
    ready_nxt = ready_r;
    pend_nxt  = pend_r;
    pzero_nxt = pzero_r;
    if (ctl.clr_hist) begin
      ready_nxt = 1'b1;
    end
    if (pend_r && can_load) begin
      pend_nxt = 1'b0;
    end
    if (xfer && is_sample) begin
      pend_nxt  = 1'b1;
      pzero_nxt = !ready_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      pend_r  <= 1'b0;
      pzero_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
      pend_r  <= pend_nxt;
      pzero_r <= pzero_nxt;
    end
  end

  // Tap chain: the last cell sees a zero sum from beyond the end
  assign s_chain[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic tap_we;
    // Indexes at or above TAPS select no cell and drop the coefficient
    assign tap_we = ctl.clr_hist && (32'(tap_index) == 32'(k));

    fcf_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tap_we (tap_we),
      .coef   (coefficient),
      .x      (sample),
      .s_in   (s_chain[k+1]),
      .s_out  (s_chain[k])
    );
  end

  fcf_outreg #(
    .ACC_W (ACC_W)
  ) u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (pend_r && can_load),
    .zero       (pzero_r),
    .sum        (s_chain[0]),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (res_sample),
    .out_clip   (out_tuser)
  );

  assign out_tdata = res_sample;

endmodule
